### rtl/mmcs_pkg.sv
// Shared types, codes and keyword tables for the mission mode command sequencer.
// No dependencies; every rtl module imports this package.
package mmcs_pkg;

  localparam int KW_COUNT = 11;
  localparam int KW_MAXLEN = 16;
  localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Keywords, right-justified in 16 bytes, first character in the highest used byte
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
    {"GET", "_STATUS"}, {"ENTER", "_TEST_MODE"}, {"EXIT", "_TEST_MODE"},
    {"FLIGHT", "_READY"}, {"AWAIT", "_SOE"}, "LEDS_ON", {"LEDS", "_OFF"},
    "CAM_ON", "CAM_OFF", {"SAFE", "_SHUTDOWN"}, "HELP"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd10, 4'd15, 4'd14, 4'd12, 4'd9, 4'd7, 4'd8, 4'd6, 4'd7, 4'd13, 4'd4
  };

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_GROUND   = 3'd1,
    MODE_TEST     = 3'd2,
    MODE_READY    = 3'd3,
    MODE_AWAIT    = 3'd4,
    MODE_ACTIVE   = 3'd5,
    MODE_SHUTDOWN = 3'd6,
    MODE_ERROR    = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    CMD_STATUS     = 4'd0,
    CMD_ENTER_TEST = 4'd1,
    CMD_EXIT_TEST  = 4'd2,
    CMD_FLIGHT_RDY = 4'd3,
    CMD_ARM_START  = 4'd4,
    CMD_LEDS_ON    = 4'd5,
    CMD_LIGHTS_OFF = 4'd6,
    CMD_CAM_ON     = 4'd7,
    CMD_CAM_OFF    = 4'd8,
    CMD_SHUTDOWN   = 4'd9,
    CMD_HELP       = 4'd10,
    CMD_UNKNOWN    = 4'd11
  } cmd_t;

  typedef enum logic [4:0] {
    RESP_STATUS       = 5'd0,
    RESP_TEST_ACK     = 5'd1,
    RESP_TEST_ERR     = 5'd2,
    RESP_EXIT_ACK     = 5'd3,
    RESP_EXIT_ERR     = 5'd4,
    RESP_READY_ACK    = 5'd5,
    RESP_READY_ERR    = 5'd6,
    RESP_AWAIT_ACK    = 5'd7,
    RESP_AWAIT_ERR    = 5'd8,
    RESP_LEDS_ON_ACK  = 5'd9,
    RESP_LEDS_ON_ERR  = 5'd10,
    RESP_LIGHTS_OFF   = 5'd11,
    RESP_CAM_ON_ACK   = 5'd12,
    RESP_CAM_ON_ERR   = 5'd13,
    RESP_CAM_OFF      = 5'd14,
    RESP_SHUTDOWN     = 5'd15,
    RESP_HELP         = 5'd16,
    RESP_UNKNOWN      = 5'd17,
    RESP_TOO_LONG     = 5'd18,
    RESP_STARTED      = 5'd19
  } resp_t;

  typedef enum logic [1:0] {
    EV_TICK     = 2'd0,
    EV_CMD      = 2'd1,
    EV_TOO_LONG = 2'd2
  } ev_kind_t;

  // Classified event handed from the line front end to the executor
  typedef struct packed {
    ev_kind_t kind;
    cmd_t     cmd;
    logic     start;
    logic     liftoff;
  } ev_t;

  // Character of keyword k at line position pos, NUL beyond its end
  function automatic logic [7:0] kw_char(input int k, input logic [6:0] pos);
    logic [8*KW_MAXLEN-1:0] txt;
    int idx;
    txt = KW_TEXT[k];
    idx = int'(KW_LEN[k]) - 1 - int'(pos);
    if (idx < 0) begin
      return CHAR_NUL;
    end
    return txt[8*idx +: 8];
  endfunction

  // Keywords whose length equals len
  function automatic logic [KW_COUNT-1:0] len_mask(input logic [6:0] len);
    logic [KW_COUNT-1:0] m;
    m = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (7'(KW_LEN[k]) == len) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

### rtl/mmcs_front.sv
// Front end: takes bytes and ticks, builds the line match state, classifies events.
// Depends on mmcs_pkg.
module mmcs_front
  import mmcs_pkg::*;
#(
  parameter int LINE_CAPACITY = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       in_start_level,
  input  logic       in_liftoff_level,
  input  logic       q_full,
  output logic       push,
  output ev_t        push_ev
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [KW_COUNT-1:0] match_r, match_nxt;
  logic                ended_r, ended_nxt;

  logic                accept;
  logic [KW_COUNT-1:0] eol_mask;
  logic                eol_none;
  cmd_t                eol_cmd;
  logic [KW_COUNT-1:0] cmp_mask;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Resolve the command a newline would select
  always_comb begin
    eol_mask = ended_r ? match_r : (match_r & len_mask(7'(len_r)));
    eol_none = ended_r ? (match_r == KW_ALL) : (len_r == '0);
    eol_cmd  = CMD_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (eol_mask[k]) begin
        eol_cmd = cmd_t'(4'(k));
      end
    end
  end

  // Compare the incoming byte against each keyword at the current position
  always_comb begin
    cmp_mask = match_r;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (in_rx_byte != kw_char(k, 7'(len_r))) begin
        cmp_mask[k] = 1'b0;
      end
    end
  end

  // Advance the line state and raise events
  always_comb begin
    len_nxt         = len_r;
    match_nxt       = match_r;
    ended_nxt       = ended_r;
    push            = 1'b0;
    push_ev.kind    = EV_CMD;
    push_ev.cmd     = eol_cmd;
    push_ev.start   = in_start_level;
    push_ev.liftoff = in_liftoff_level;
    if (accept) begin
      if (in_op == OP_TICK) begin
        push_ev.kind = EV_TICK;
        push         = in_start_level;
      end else if (in_rx_byte == CHAR_CR) begin
        // ignore carriage return
      end else if (in_rx_byte == CHAR_LF) begin
        push      = !eol_none;
        len_nxt   = '0;
        match_nxt = KW_ALL;
        ended_nxt = 1'b0;
      end else if (len_r < LEN_W'(LINE_CAPACITY - 1)) begin
        if (!ended_r) begin
          if (in_rx_byte == CHAR_NUL) begin
            if (len_r != '0) begin
              match_nxt = match_r & len_mask(7'(len_r));
            end
            ended_nxt = 1'b1;
          end else begin
            match_nxt = cmp_mask;
          end
        end
        len_nxt = len_r + 1'b1;
      end else begin
        // drop the overlong line
        push_ev.kind = EV_TOO_LONG;
        push         = 1'b1;
        len_nxt      = '0;
        match_nxt    = KW_ALL;
        ended_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      match_r <= KW_ALL;
      ended_r <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      match_r <= match_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### rtl/mmcs_queue.sv
// Two-entry event queue between the front end and the executor.
// Depends on mmcs_pkg for the event type.
module mmcs_queue
  import mmcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_ev,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output ev_t  head_ev
);

  ev_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_ev    = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == 2'($past(count_r) + 2'd1))
    else $error("push did not grow queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/mmcs_back.sv
// Executor: applies events to the mission mode and enables, registers the response.
// Depends on mmcs_pkg.
module mmcs_back
  import mmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  ev_t        head_ev,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_response,
  output logic [2:0] out_mode,
  output logic       out_camera_on,
  output logic       out_lights_on,
  output logic       out_start_seen,
  output logic       out_liftoff_seen
);

  mode_t mode_r, mode_nxt;
  logic  cam_r, cam_nxt;
  logic  leds_r, leds_nxt;

  logic  out_valid_r;
  resp_t resp_r;
  mode_t omode_r;
  logic  ocam_r, oleds_r, ostart_r, olift_r;

  logic  has_res;
  resp_t resp;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  // Next mode and enables
  always_comb begin
    mode_nxt = mode_r;
    cam_nxt  = cam_r;
    leds_nxt = leds_r;
    if (pop) begin
      unique case (head_ev.kind)
        EV_TICK: begin
          if (mode_r == MODE_AWAIT && head_ev.start) begin
            mode_nxt = MODE_ACTIVE;
            cam_nxt  = 1'b1;
            leds_nxt = 1'b1;
          end
        end
        EV_CMD: begin
          unique case (head_ev.cmd)
            CMD_ENTER_TEST: begin
              if (mode_r == MODE_GROUND || mode_r == MODE_READY) begin
                mode_nxt = MODE_TEST;
              end
            end
            CMD_EXIT_TEST: begin
              if (mode_r == MODE_TEST) begin
                mode_nxt = MODE_GROUND;
                cam_nxt  = 1'b0;
                leds_nxt = 1'b0;
              end
            end
            CMD_FLIGHT_RDY: begin
              if (mode_r == MODE_GROUND || mode_r == MODE_TEST) begin
                mode_nxt = MODE_READY;
                cam_nxt  = 1'b0;
                leds_nxt = 1'b0;
              end
            end
            CMD_ARM_START: begin
              if (mode_r == MODE_READY) begin
                mode_nxt = MODE_AWAIT;
              end
            end
            CMD_LEDS_ON: begin
              if (mode_r == MODE_TEST) begin
                leds_nxt = 1'b1;
              end
            end
            CMD_LIGHTS_OFF: leds_nxt = 1'b0;
            CMD_CAM_ON: begin
              if (mode_r == MODE_TEST) begin
                cam_nxt = 1'b1;
              end
            end
            CMD_CAM_OFF: cam_nxt = 1'b0;
            CMD_SHUTDOWN: begin
              mode_nxt = MODE_SHUTDOWN;
              cam_nxt  = 1'b0;
              leds_nxt = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Response code for the head event
  always_comb begin
    has_res = 1'b1;
    resp    = RESP_UNKNOWN;
    unique case (head_ev.kind)
      EV_TICK: begin
        has_res = (mode_r == MODE_AWAIT) && head_ev.start;
        resp    = RESP_STARTED;
      end
      EV_TOO_LONG: resp = RESP_TOO_LONG;
      EV_CMD: begin
        unique case (head_ev.cmd)
          CMD_STATUS:     resp = RESP_STATUS;
          CMD_ENTER_TEST: resp = (mode_r == MODE_GROUND || mode_r == MODE_READY)
                                 ? RESP_TEST_ACK : RESP_TEST_ERR;
          CMD_EXIT_TEST:  resp = (mode_r == MODE_TEST) ? RESP_EXIT_ACK : RESP_EXIT_ERR;
          CMD_FLIGHT_RDY: resp = (mode_r == MODE_GROUND || mode_r == MODE_TEST)
                                 ? RESP_READY_ACK : RESP_READY_ERR;
          CMD_ARM_START:  resp = (mode_r == MODE_READY) ? RESP_AWAIT_ACK : RESP_AWAIT_ERR;
          CMD_LEDS_ON:    resp = (mode_r == MODE_TEST) ? RESP_LEDS_ON_ACK : RESP_LEDS_ON_ERR;
          CMD_LIGHTS_OFF: resp = RESP_LIGHTS_OFF;
          CMD_CAM_ON:     resp = (mode_r == MODE_TEST) ? RESP_CAM_ON_ACK : RESP_CAM_ON_ERR;
          CMD_CAM_OFF:    resp = RESP_CAM_OFF;
          CMD_SHUTDOWN:   resp = RESP_SHUTDOWN;
          CMD_HELP:       resp = RESP_HELP;
          default:        resp = RESP_UNKNOWN;
        endcase
      end
      default: has_res = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GROUND;
      cam_r       <= 1'b0;
      leds_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cam_r  <= cam_nxt;
      leds_r <= leds_nxt;
      if (pop) begin
        out_valid_r <= has_res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      resp_r   <= resp;
      omode_r  <= mode_nxt;
      ocam_r   <= cam_nxt;
      oleds_r  <= leds_nxt;
      ostart_r <= head_ev.start;
      olift_r  <= head_ev.liftoff;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_response     = resp_r;
  assign out_mode         = omode_r;
  assign out_camera_on    = ocam_r;
  assign out_lights_on    = oleds_r;
  assign out_start_seen   = ostart_r;
  assign out_liftoff_seen = olift_r;

endmodule

### rtl/mission_mode_command_sequencer.sv
// Flow: an accepted item is written into the event queue; the executor pops it
// and loads the output register once that register is empty or not stalled.
// Throughput: one item per cycle; input stalls only while the two-entry event
// queue is full, which happens when the result side holds stall.
// Reset (synchronous, rst_n low): ground link mode, camera and LEDs off,
// line cleared, queue and output register empty.
module mission_mode_command_sequencer
  import mmcs_pkg::*;
#(
  parameter int LINE_CAPACITY = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       in_start_level,
  input  logic       in_liftoff_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_response,
  output logic [2:0] out_mode,
  output logic       out_camera_on,
  output logic       out_lights_on,
  output logic       out_start_seen,
  output logic       out_liftoff_seen
);

  logic q_full, push, pop, head_valid;
  ev_t  push_ev, head_ev;

  mmcs_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_rx_byte      (in_rx_byte),
    .in_start_level  (in_start_level),
    .in_liftoff_level(in_liftoff_level),
    .q_full          (q_full),
    .push            (push),
    .push_ev         (push_ev)
  );

  mmcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ev   (push_ev),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_ev   (head_ev)
  );

  mmcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_ev         (head_ev),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_response    (out_response),
    .out_mode        (out_mode),
    .out_camera_on   (out_camera_on),
    .out_lights_on   (out_lights_on),
    .out_start_seen  (out_start_seen),
    .out_liftoff_seen(out_liftoff_seen)
  );

endmodule
